/* hw/rtl/asdx_pkg.sv */
package asdx_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned MAX_PAYLOAD_DEF = 128;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Framing characters
    localparam logic [7:0] CH_START = 8'h23;  // '#'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_NL    = 8'h0A;  // '\n'

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Message classes
    localparam logic [1:0] CLS_IMU  = 2'd0;
    localparam logic [1:0] CLS_GNSS = 2'd1;
    localparam logic [1:0] CLS_INS  = 2'd2;
    localparam logic [1:0] CLS_NONE = 2'd3;

    localparam int unsigned HDR_LEN   = 5;
    localparam int unsigned HDR_COUNT = 4;

    // Known headers and the class of each
    localparam logic [0:HDR_COUNT-1][0:HDR_LEN-1][7:0] HDR_TABLE = '{
        '{8'h41, 8'h50, 8'h49, 8'h4D, 8'h55},  // APIMU
        '{8'h41, 8'h50, 8'h47, 8'h50, 8'h53},  // APGPS
        '{8'h41, 8'h50, 8'h47, 8'h50, 8'h32},  // APGP2
        '{8'h41, 8'h50, 8'h49, 8'h4E, 8'h53}   // APINS
    };
    localparam logic [0:HDR_COUNT-1][1:0] HDR_CLASS = '{CLS_IMU, CLS_GNSS, CLS_GNSS, CLS_INS};

    // Frame phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_BODY,
        PH_SUM
    } phase_t;

    // Classified input character
    typedef struct packed {
        logic [7:0] rx_char;
        logic       is_start;
        logic       is_comma;
        logic       is_star;
        logic       is_nl;
        logic       is_hex;
        logic [3:0] hex_val;
    } tok_t;

    // One result item
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] msg_class;
        logic       frame_ok;
        logic [7:0] payload_len;
    } res_t;

    // Class of a held header, CLS_NONE when unknown or not five characters
    function automatic logic [1:0] match_header(input logic [0:HDR_LEN-1][7:0] chars,
                                                input logic [2:0] count);
        logic [1:0] cls;
        cls = CLS_NONE;
        if (count == 3'(HDR_LEN))
        begin
            for (int i = HDR_COUNT - 1; i >= 0; i--)
            begin
                if (chars == HDR_TABLE[i])
                begin
                    cls = HDR_CLASS[i];
                end
            end
        end
        return cls;
    endfunction

endpackage

/* hw/rtl/ascii_sentence_deframer_xor_core.sv */
// Channel  Dir  tdata fields (low bit up)                        tuser
// s_*      in   rx_byte[7:0]                                     -
// m_*      out  data_byte[7:0] msg_class[9:8] frame_ok[10]       kind
//               payload_len[18:11], zero pad [23:19]
//
// While m_tready is high the rate is one byte per cycle; the back-end state machine
// retires one queued character per cycle and loads the output register in the
// same cycle. A byte passes through the queue and then the output register.
// rst_n clears the queue, the frame state and the output valid flag asynchronously.
// A stall on m_tready fills the character queue; s_tready drops only when it is full.
module ascii_sentence_deframer_xor_core #(
    parameter int unsigned MAX_PAYLOAD = asdx_pkg::MAX_PAYLOAD_DEF,
    parameter int unsigned QUEUE_DEPTH = asdx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_byte, msg_class, frame_ok, payload_len, pad
    output logic        m_tuser    // kind
);
    import asdx_pkg::*;

    logic push;
    tok_t push_tok;
    logic q_full;
    logic q_valid;
    tok_t q_tok;
    logic pop;
    res_t res;

    asdx_front u_front (
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .s_tready (s_tready),
        .push     (push),
        .tok      (push_tok)
    );

    asdx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_tok    (q_tok)
    );

    asdx_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_tok     (q_tok),
        .pop       (pop),
        .res_ready (m_tready),
        .res_valid (m_tvalid),
        .res       (res)
    );

    // Pack the result beat
    assign m_tuser = res.kind;
    assign m_tdata = {5'd0, res.payload_len, res.frame_ok, res.msg_class, res.data_byte};

endmodule

/* hw/rtl/asdx_front.sv */
module asdx_front (
    input  logic              s_tvalid,
    input  logic [7:0]        s_tdata,
    input  logic              q_full,
    output logic              s_tready,
    output logic              push,
    output asdx_pkg::tok_t    tok
);
    import asdx_pkg::*;

    // Accept whenever the queue has room; high bytes are taken and dropped
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full && !s_tdata[7];

    // Classify the character
    always_comb
    begin
        tok.rx_char  = s_tdata;
        tok.is_start = (s_tdata == CH_START);
        tok.is_comma = (s_tdata == CH_COMMA);
        tok.is_star  = (s_tdata == CH_STAR);
        tok.is_nl    = (s_tdata == CH_NL);
        tok.is_hex   = 1'b0;
        tok.hex_val  = 4'd0;
        if (s_tdata >= 8'h30 && s_tdata <= 8'h39)
        begin
            tok.is_hex  = 1'b1;
            tok.hex_val = 4'(s_tdata - 8'h30);
        end
        else if (s_tdata >= 8'h41 && s_tdata <= 8'h46)
        begin
            tok.is_hex  = 1'b1;
            tok.hex_val = 4'(s_tdata - 8'h37);
        end
        else if (s_tdata >= 8'h61 && s_tdata <= 8'h66)
        begin
            tok.is_hex  = 1'b1;
            tok.hex_val = 4'(s_tdata - 8'h57);
        end
    end

endmodule

/* hw/rtl/asdx_queue.sv */
module asdx_queue #(
    parameter int unsigned DEPTH = asdx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  asdx_pkg::tok_t    push_tok,
    input  logic              pop,
    output logic              full,
    output logic              q_valid,
    output asdx_pkg::tok_t    q_tok
);
    import asdx_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    tok_t            mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CntW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_tok   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Advance pointers with wrap and track fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

    // Fill never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("queue fill above depth");

    // A push into a full queue without a pop keeps it full
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> full)
        else $error("queue lost an entry");

endmodule

/* hw/rtl/asdx_back.sv */
module asdx_back #(
    parameter int unsigned MAX_PAYLOAD = asdx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  asdx_pkg::tok_t    q_tok,
    output logic              pop,
    input  logic              res_ready,
    output logic              res_valid,
    output asdx_pkg::res_t    res
);
    import asdx_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

    phase_t      phase_reg, phase_next;
    logic [7:0]  hdr_reg [HDR_LEN];
    logic [0:HDR_LEN-1][7:0] hdr_vec;
    logic [2:0]  hcount_reg, hcount_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  sum_reg, sum_next;
    logic [1:0]  dcount_reg, dcount_next;
    logic [7:0]  bcount_reg, bcount_next;
    logic [1:0]  cls_reg, cls_next;
    logic        bad_reg, bad_next;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg, out_next;
    logic        hdr_we;
    logic [1:0]  hdr_cls;
    logic        gen;
    res_t        gen_res;

    always_comb
    begin
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hdr_vec[i] = hdr_reg[i];
        end
    end
    assign hdr_cls = match_header(hdr_vec, hcount_reg);

    // Take a character whenever the output register is free or draining
    assign pop = q_valid && (!out_valid_reg || res_ready);

    // Frame state machine
    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        xor_next    = xor_reg;
        sum_next    = sum_reg;
        dcount_next = dcount_reg;
        bcount_next = bcount_reg;
        cls_next    = cls_reg;
        bad_next    = bad_reg;
        hdr_we      = 1'b0;
        gen         = 1'b0;
        gen_res     = '0;
        if (pop)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (q_tok.is_start)
                    begin
                        phase_next  = PH_HEAD;
                        hcount_next = '0;
                        xor_next    = '0;
                        sum_next    = '0;
                        dcount_next = '0;
                        bcount_next = '0;
                        bad_next    = 1'b0;
                        cls_next    = CLS_IMU;
                    end
                end
                PH_HEAD:
                begin
                    if (q_tok.is_comma)
                    begin
                        if (hdr_cls == CLS_NONE)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            cls_next   = hdr_cls;
                            xor_next   = xor_reg ^ q_tok.rx_char;
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        xor_next = xor_reg ^ q_tok.rx_char;
                        hdr_we   = (hcount_reg < 3'(HDR_LEN));
                        if (hcount_reg < 3'(HDR_LEN + 1))
                        begin
                            hcount_next = hcount_reg + 1'b1;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (q_tok.is_star)
                    begin
                        phase_next  = PH_SUM;
                        dcount_next = '0;
                        sum_next    = '0;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ q_tok.rx_char;
                        if (bcount_reg >= MaxLen)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            bcount_next       = bcount_reg + 1'b1;
                            gen               = 1'b1;
                            gen_res.kind      = KIND_PAYLOAD;
                            gen_res.data_byte = q_tok.rx_char;
                            gen_res.msg_class = cls_reg;
                        end
                    end
                end
                PH_SUM:
                begin
                    if (!q_tok.is_nl)
                    begin
                        if (!q_tok.is_hex || dcount_reg >= 2'd2)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            sum_next    = {sum_reg[3:0], q_tok.hex_val};
                            dcount_next = dcount_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        gen                 = 1'b1;
                        gen_res.kind        = KIND_END;
                        gen_res.msg_class   = cls_reg;
                        gen_res.frame_ok    = !bad_reg && (dcount_reg == 2'd2)
                                              && (sum_reg == xor_reg);
                        gen_res.payload_len = bcount_reg;
                        phase_next          = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Load the output register or drain it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (gen)
        begin
            out_valid_next = 1'b1;
            out_next       = gen_res;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hcount_reg    <= '0;
            xor_reg       <= '0;
            sum_reg       <= '0;
            dcount_reg    <= '0;
            bcount_reg    <= '0;
            cls_reg       <= CLS_IMU;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hcount_reg    <= hcount_next;
            xor_reg       <= xor_next;
            sum_reg       <= sum_next;
            dcount_reg    <= dcount_next;
            bcount_reg    <= bcount_next;
            cls_reg       <= cls_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold header characters and the result payload
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[hcount_reg] <= q_tok.rx_char;
        end
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // A payload beat carries no verdict and no length
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == KIND_PAYLOAD
        |-> !out_reg.frame_ok && out_reg.payload_len == 8'd0)
        else $error("payload beat with verdict fields set");

    // Payload count never passes the limit
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bcount_reg <= MaxLen)
        else $error("payload count above limit");

    // Checksum digits and header count saturate
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dcount_reg <= 2'd2 && hcount_reg <= 3'(HDR_LEN + 1))
        else $error("digit or header count out of range");

    // A stalled result is not overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ready |-> !pop)
        else $error("result overwritten while stalled");

endmodule
